>>> hw/rtl/software_timer_table_assert.svh
// Assertion macros for the software timer table
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define STT_ASSERT(label, clk, rstn, prop, msg)
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/stt_pkg.sv
// Types and constants shared by the software timer table modules
package stt_pkg;
    localparam int unsigned OpW    = 3;
    localparam int unsigned IdW    = 4;
    localparam int unsigned MsW    = 24;
    localparam int unsigned BaseW  = 16;
    localparam int unsigned TimeW  = 40;
    localparam int unsigned MaxSlots = 16;

    localparam logic [OpW-1:0] OP_ADD     = 3'd0;
    localparam logic [OpW-1:0] OP_DELETE  = 3'd1;
    localparam logic [OpW-1:0] OP_TICK    = 3'd2;
    localparam logic [OpW-1:0] OP_QREM    = 3'd3;
    localparam logic [OpW-1:0] OP_QELAPSE = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OpW-1:0] opcode;
        logic [IdW-1:0] timer_id;
        logic [MsW-1:0] interval_ms;
        logic           periodic;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IdW-1:0]   result_id;
        logic [TimeW-1:0] time_ms;
        logic             expired;
        logic             last;
    } rsp_t;

    // divider control/status between sequencer and divider
    typedef struct packed {
        logic             start;
        logic [MsW-1:0]   dividend;
        logic [BaseW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [MsW-1:0] quotient;
    } div_rsp_t;
endpackage

>>> hw/rtl/software_timer_table.sv
// Top level of the software timer table: sequencer, slot store, output register
//
// Usage: s_valid/s_ready/s_data carry one operation (add, delete, tick, query
// remaining, query elapsed). Results come out on m_valid/m_ready/m_data, one
// or more per operation, the final one flagged by last. cfg_we/cfg_wdata set
// the tick base in milliseconds (reset value 10); write it only while idle.
// One operation at a time: s_ready is high only while the sequencer is idle
// and no result is waiting, so the next input transfer can come the cycle
// after the final result of the previous operation transfers.
// An add waits for the 24 steps of the bit-serial divider; queries pass
// through one registered multiply.
// Tick: walks the slots (min(NUM_TIMERS,16)) one per cycle while no released
// expiry waits to transfer. An expiry is held until the walk knows whether
// another follows; each further expiry releases the held one and stalls the
// walk until it transfers, so receiver stalls slow the walk.
// Reset empties the table; no clearing pass. When the receiver stalls, the
// sequencer holds the pending result and waits, nothing is dropped.
module software_timer_table #(
    parameter int unsigned NUM_TIMERS = 16,
    parameter int unsigned TICK_BITS  = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  stt_pkg::req_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output stt_pkg::rsp_t                   m_data,
    input  logic                            cfg_we,
    input  logic [stt_pkg::BaseW-1:0]       cfg_wdata
);
    `include "software_timer_table_assert.svh"

    localparam int unsigned Slots = (NUM_TIMERS < stt_pkg::MaxSlots) ?
                                    NUM_TIMERS : stt_pkg::MaxSlots;
    localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
    localparam int unsigned IdW = stt_pkg::IdW;
    localparam int unsigned MsW = stt_pkg::MsW;
    localparam int unsigned BaseW = stt_pkg::BaseW;
    localparam int unsigned TimeW = stt_pkg::TimeW;
    localparam logic [TICK_BITS-1:0] TickMax = '1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_TICK  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [BaseW-1:0] base_reg;
    stt_pkg::req_t req_reg;
    stt_pkg::rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    // out_reg holds an expiry whose last flag is not known yet
    logic hold_reg, hold_next;

    logic [Slots-1:0] valid_reg, valid_next;
    logic [Slots-1:0] per_reg;
    logic [TICK_BITS-1:0] period_mem [Slots];
    logic [TICK_BITS-1:0] remain_mem [Slots];

    logic [SW-1:0] idx_reg, idx_next;
    logic [SW-1:0] free_idx;
    logic          free_any;
    logic          any_exp_reg, any_exp_next;
    logic [TimeW-1:0] prod_reg;
    logic [TICK_BITS-1:0] tsel;

    // write port of the slot store
    logic                 wr_en;
    logic [SW-1:0]        wr_idx;
    logic [TICK_BITS-1:0] wr_rem;
    logic                 wr_load;
    logic [TICK_BITS-1:0] wr_per;
    logic                 wr_pflag;

    stt_pkg::div_req_t div_req;
    stt_pkg::div_rsp_t div_rsp;

    stt_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    logic          id_in_range;
    logic          id_ok;
    logic [SW-1:0] id_sel;
    logic [TICK_BITS-1:0] cur_rem, cur_per, dec_rem;

    assign id_in_range = {28'd0, req_reg.timer_id} < 32'(Slots);
    assign id_sel      = SW'(req_reg.timer_id);
    assign id_ok       = id_in_range && valid_reg[id_sel];

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = Slots - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign cur_rem = remain_mem[idx_reg];
    assign cur_per = period_mem[idx_reg];
    assign dec_rem = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;

    always_comb begin
        tsel = '0;
        if (req_reg.opcode == stt_pkg::OP_QREM) begin
            tsel = remain_mem[id_sel];
        end else if (period_mem[id_sel] >= remain_mem[id_sel]) begin
            tsel = period_mem[id_sel] - remain_mem[id_sel];
        end
    end

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        any_exp_next   = any_exp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hold_next      = hold_reg;
        div_req        = '0;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        wr_rem         = '0;
        wr_load        = 1'b0;
        wr_per         = '0;
        wr_pflag       = 1'b0;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                out_next = '{status: stt_pkg::ST_OK, result_id: '0, time_ms: '0,
                             expired: 1'b0, last: 1'b1};
                case (req_reg.opcode)
                    stt_pkg::OP_ADD: begin
                        if (base_reg == '0 || req_reg.interval_ms < MsW'(base_reg)) begin
                            out_next.status = stt_pkg::ST_BAD;
                            state_next = S_OUT;
                        end else if (!free_any) begin
                            out_next.status = stt_pkg::ST_FULL;
                            state_next = S_OUT;
                        end else begin
                            idx_next = free_idx;
                            div_req.start    = 1'b1;
                            div_req.dividend = req_reg.interval_ms;
                            div_req.divisor  = base_reg;
                            state_next = S_DIV;
                        end
                    end
                    stt_pkg::OP_DELETE: begin
                        if (id_ok) begin
                            valid_next[id_sel] = 1'b0;
                        end else begin
                            out_next.status = stt_pkg::ST_BAD;
                        end
                        state_next = S_OUT;
                    end
                    stt_pkg::OP_TICK: begin
                        idx_next     = '0;
                        any_exp_next = 1'b0;
                        state_next   = S_TICK;
                    end
                    stt_pkg::OP_QREM, stt_pkg::OP_QELAPSE: begin
                        if (id_ok) begin
                            state_next = S_MUL;
                        end else begin
                            out_next.status = stt_pkg::ST_BAD;
                            state_next = S_OUT;
                        end
                    end
                    default: begin
                        out_next.status = stt_pkg::ST_BAD;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    wr_en    = 1'b1;
                    wr_load  = 1'b1;
                    wr_pflag = req_reg.periodic;
                    // saturate long periods
                    if (MsW > TICK_BITS && (div_rsp.quotient > MsW'(TickMax))) begin
                        wr_per = TickMax;
                    end else begin
                        wr_per = TICK_BITS'(div_rsp.quotient);
                    end
                    wr_rem = wr_per;
                    valid_next[idx_reg] = 1'b1;
                    out_next.result_id = IdW'(idx_reg);
                    state_next = S_OUT;
                end
            end
            S_TICK: begin
                // one slot per cycle; a released expiry must transfer first
                if (!out_valid_reg || hold_reg) begin
                    if (hold_reg && valid_reg[idx_reg] && dec_rem == '0) begin
                        // another expiry follows: the held one goes out as not last
                        hold_next = 1'b0;
                    end else begin
                        if (valid_reg[idx_reg]) begin
                            wr_en = 1'b1;
                            if (dec_rem == '0) begin
                                if (per_reg[idx_reg]) begin
                                    wr_rem = cur_per;
                                end else begin
                                    wr_rem = dec_rem;
                                    valid_next[idx_reg] = 1'b0;
                                end
                                any_exp_next   = 1'b1;
                                out_valid_next = 1'b1;
                                hold_next      = 1'b1;
                                out_next = '{status: stt_pkg::ST_OK,
                                             result_id: IdW'(idx_reg),
                                             time_ms: '0, expired: 1'b1, last: 1'b0};
                            end else begin
                                wr_rem = dec_rem;
                            end
                        end
                        if (32'(idx_reg) == Slots - 1) begin
                            state_next = S_DONE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                // the held expiry becomes last, or emit the no-expiry result
                if (hold_reg) begin
                    out_next.last = 1'b1;
                    hold_next  = 1'b0;
                    state_next = S_IDLE;
                end else if (!any_exp_reg) begin
                    out_next = '{status: stt_pkg::ST_OK, result_id: '0, time_ms: '0,
                                 expired: 1'b0, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    // an expiry is always held at the end of the walk
                    state_next = S_IDLE;
                end
            end
            S_MUL: begin
                out_next.time_ms = prod_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            base_reg      <= BaseW'(10);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            idx_reg       <= '0;
            any_exp_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            idx_reg       <= idx_next;
            any_exp_reg   <= any_exp_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        out_reg  <= out_next;
        prod_reg <= TimeW'(tsel) * TimeW'(base_reg);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            remain_mem[wr_idx] <= wr_rem;
            if (wr_load) begin
                period_mem[wr_idx] <= wr_per;
                per_reg[wr_idx]    <= wr_pflag;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_data  = out_reg;
    assign m_valid = out_valid_reg && !hold_reg;

    `STT_ASSERT(a_ready_idle, aclk, aresetn, !(s_ready && state_reg != S_IDLE), "ready outside idle")
    `STT_ASSERT_NEXT(a_add_div, aclk, aresetn, div_req.start, state_reg == S_DIV, "divider start without wait")
    `STT_ASSERT(a_out_last, aclk, aresetn, !(m_valid && state_reg == S_IDLE && !m_data.expired && !m_data.last), "non-expiry result lacks last")
endmodule

>>> hw/rtl/stt_divider.sv
// Restoring divider, one quotient bit per cycle
module stt_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  stt_pkg::div_req_t req,
    output stt_pkg::div_rsp_t rsp
);
    localparam int unsigned MsW = stt_pkg::MsW;
    localparam int unsigned BaseW = stt_pkg::BaseW;
    localparam int unsigned CntW = $clog2(MsW + 1);

    logic             busy_reg, busy_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [MsW-1:0]   quo_reg, quo_next;
    logic [BaseW:0]   rem_reg, rem_next;
    logic [BaseW-1:0] dvs_reg, dvs_next;
    logic             done_reg, done_next;
    logic [BaseW+1:0] trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CntW'(MsW);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // shift next dividend bit into the partial remainder
            trial = {rem_reg, quo_reg[MsW-1]} - {2'b00, dvs_reg};
            if (!trial[BaseW+1]) begin
                rem_next = trial[BaseW:0];
                quo_next = {quo_reg[MsW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[BaseW-1:0], quo_reg[MsW-1]};
                quo_next = {quo_reg[MsW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
